// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY = 8;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OCC_W    = 4;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic enq;
    logic deq;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl
// Request decode, status code and result strobe sequencing.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                command_i,
  input  spq_pkg::dp_stat_t   stat_i,
  output spq_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o,
  output logic                done_o,
  output logic [1:0]          status_o
);

  spq_pkg::state_e  state_q, state_d;
  spq_pkg::status_e status_q, status_d;
  logic             accept;

  // one request per cycle: the result register frees up every cycle
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = accept ? spq_pkg::S_RESP : spq_pkg::S_IDLE;
  end

  always_comb begin
    cmd_o.capture = accept;
    cmd_o.enq     = 1'b0;
    cmd_o.deq     = 1'b0;
    status_d      = status_q;
    if (accept) begin
      unique case (spq_pkg::cmd_e'(command_i))
        spq_pkg::CMD_ENQ: begin
          cmd_o.enq = !stat_i.full;
          status_d  = stat_i.full ? spq_pkg::STAT_FULL : spq_pkg::STAT_OK;
        end
        spq_pkg::CMD_DEQ: begin
          cmd_o.deq = !stat_i.empty;
          status_d  = stat_i.empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
        end
        default: begin
          status_d = spq_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_comb begin
    done_o   = (state_q == spq_pkg::S_RESP);
    status_o = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= spq_pkg::S_IDLE;
      status_q <= spq_pkg::STAT_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== rtl/core/spq_dpath.sv =====
// ----------------------------------------------------------------------------
// spq_dpath
// Sorted entry chain with parallel compare insert and shift-out on dequeue.
// ----------------------------------------------------------------------------
module spq_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spq_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [spq_pkg::DATA_W-1:0]   value_i,
  output spq_pkg::dp_stat_t                   stat_o,
  output logic signed [spq_pkg::DATA_W-1:0]   result_value_o,
  output logic [spq_pkg::OCC_W-1:0]           occupancy_o
);

  logic signed [spq_pkg::DATA_W-1:0] entries_q [spq_pkg::CAPACITY];
  logic signed [spq_pkg::DATA_W-1:0] entries_d [spq_pkg::CAPACITY];
  logic [spq_pkg::CNT_W-1:0]         count_q, count_d;
  logic [spq_pkg::CAPACITY-1:0]      take;
  logic signed [spq_pkg::DATA_W-1:0] res_q, res_d;
  logic [spq_pkg::OCC_W-1:0]         occ_q;

  assign stat_o.full  = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign stat_o.empty = (count_q == '0);

  // take[i]: slot i is at or past the insertion point (monotone mask)
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      take[i] = (spq_pkg::CNT_W'(i) >= count_q) || (value_i > entries_q[i]);
    end
  end

  always_comb begin
    count_d = count_q;
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
    end
    if (cmd_i.enq) begin
      count_d = count_q + 1'b1;
      for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
        if (take[i]) begin
          if (i == 0) begin
            entries_d[i] = value_i;
          end else if (!take[i-1]) begin
            entries_d[i] = value_i;
          end else begin
            entries_d[i] = entries_q[i-1];
          end
        end
      end
    end else if (cmd_i.deq) begin
      count_d = count_q - 1'b1;
      for (int i = 0; i < spq_pkg::CAPACITY - 1; i++) begin
        entries_d[i] = entries_q[i+1];
      end
    end
  end

  always_comb begin
    if (cmd_i.deq) begin
      res_d = entries_q[0];
    end else begin
      res_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      entries_q[i] <= entries_d[i];
    end
    if (cmd_i.capture) begin
      res_q <= res_d;
      occ_q <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign result_value_o = res_q;
  assign occupancy_o    = occ_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Max-priority queue of signed values kept as a sorted register chain.
// ----------------------------------------------------------------------------
// The result strobe done_o rises in the cycle after the request is taken.
// Throughput: one request per cycle; busy_o stays low and the sorted chain
//   compares all slots in parallel.
// Reset: asynchronous, clears the entry count and the strobe; entry
//   contents are not reset. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               command_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] result_value_o,
  output logic [3:0]         occupancy_o
);

  spq_pkg::dp_cmd_t                  dp_cmd;
  spq_pkg::dp_stat_t                 dp_stat;
  logic signed [spq_pkg::DATA_W-1:0] res_value;
  logic        [spq_pkg::OCC_W-1:0]  occ;
  logic        [1:0]                 empty_status;

  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .status_o  (status_o)
  );

  spq_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .value_i        (value_i),
    .stat_o         (dp_stat),
    .result_value_o (res_value),
    .occupancy_o    (occ)
  );

  // empty dequeue reports the fixed marker value
  assign empty_status   = spq_pkg::STAT_EMPTY;
  assign result_value_o = (status_o == empty_status) ? spq_pkg::EMPTY_VALUE : res_value;
  assign occupancy_o    = occ;

endmodule

// ===== rtl/core/sorted_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker
// Port-level checks on request/result timing and status consistency.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               command_i,
  input logic signed [31:0] value_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [31:0] result_value_o,
  input logic [3:0]         occupancy_o
);

  // each taken request gives exactly one strobe on the next cycle
  a_req_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("request without result strobe");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result strobe without request");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == spq_pkg::STAT_EMPTY) |->
      (result_value_o == spq_pkg::EMPTY_VALUE && occupancy_o == '0))
    else $error("empty dequeue result mismatch");

  a_full_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == spq_pkg::CMD_ENQ) |=>
      (result_value_o == $past(value_i) && status_o != spq_pkg::STAT_EMPTY))
    else $error("enqueue result does not echo the value");

endmodule

bind sorted_priority_queue sorted_priority_queue_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .command_i      (command_i),
  .value_i        (value_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .result_value_o (result_value_o),
  .occupancy_o    (occupancy_o)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted priority queue: a scoreboard keeps its
// own sorted copy of the queue, predicts status, value and occupancy for
// every request and checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned MAX_GAP      = 18;
  localparam int unsigned TAIL_CYCLES  = 4;

  typedef struct packed {
    spq_pkg::status_e   status;
    logic signed [31:0] value;
    logic [3:0]         occupancy;
  } pq_result_t;

  class pq_scoreboard;
    logic signed [31:0] sorted_q[$];  // largest first
    pq_result_t         pending[$];
    int unsigned        errors;
    int unsigned        n_enq, n_deq, n_full, n_empty, n_checked;

    function new();
      errors = 0;
      n_enq = 0;
      n_deq = 0;
      n_full = 0;
      n_empty = 0;
      n_checked = 0;
    endfunction

    function void note_request(spq_pkg::cmd_e cmd, logic signed [31:0] val);
      pq_result_t  res;
      int unsigned pos;
      res.status = spq_pkg::STAT_OK;
      if (cmd == spq_pkg::CMD_ENQ) begin
        n_enq++;
        res.value = val;
        if (sorted_q.size() >= spq_pkg::CAPACITY) begin
          res.status = spq_pkg::STAT_FULL;
          n_full++;
        end else begin
          // new value goes behind every entry greater or equal
          pos = sorted_q.size();
          while (pos > 0 && val > sorted_q[pos-1]) pos--;
          sorted_q.insert(pos, val);
        end
      end else begin
        n_deq++;
        if (sorted_q.size() == 0) begin
          res.status = spq_pkg::STAT_EMPTY;
          res.value = spq_pkg::EMPTY_VALUE;
          n_empty++;
        end else begin
          res.value = sorted_q.pop_front();
        end
      end
      res.occupancy = 4'(sorted_q.size());
      pending.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] val, logic [3:0] occ);
      pq_result_t exp_res;
      n_checked++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: status %0d value %0d occupancy %0d",
               st, val, occ);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (st !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, st);
        errors++;
      end
      if (val !== exp_res.value) begin
        $error("result_value: expected %0d, got %0d", exp_res.value, val);
        errors++;
      end
      if (occ !== exp_res.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_res.occupancy, occ);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               command_i;
  logic signed [31:0] value_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] result_value_o;
  logic [3:0]         occupancy_o;

  pq_scoreboard sb = new();
  int unsigned  cycle_count = 0;

  sorted_priority_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .occupancy_o    (occupancy_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(spq_pkg::cmd_e'(command_i), value_i);
      if (done_o) sb.check_result(status_o, result_value_o, occupancy_o);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still outstanding",
             cycle_count, sb.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return $urandom_range(0, 14) - 7;  // small range, plenty of ties
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_request(input spq_pkg::cmd_e cmd, input logic signed [31:0] val,
                              input int unsigned gap);
    if (gap > 0) begin
      start_i   <= 1'b0;
      command_i <= 1'($urandom_range(0, 1));
      value_i   <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // hold off until every outstanding request has returned
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned   enq_pct;
    int unsigned   gap_mode;
    int unsigned   gap;
    spq_pkg::cmd_e cmd;

    rst_ni    = 1'b0;
    start_i   = 1'b0;
    command_i = spq_pkg::CMD_ENQ;
    value_i   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty dequeue, extremes, ties, fill to full, drain past empty
    send_request(spq_pkg::CMD_DEQ, 32'sd0, 1);
    send_request(spq_pkg::CMD_ENQ, 32'sh7FFFFFFF, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sh80000000, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sd0, 0);
    send_request(spq_pkg::CMD_ENQ, -32'sd1, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sd5, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sd5, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sh80000000, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sh7FFFFFFF, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sd1, 0);
    send_request(spq_pkg::CMD_ENQ, 32'sh80000000, 3);
    repeat (spq_pkg::CAPACITY + 1) begin
      send_request(spq_pkg::CMD_DEQ, $urandom, $urandom_range(0, 2));
    end
    drain();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      enq_pct  = 20 + 20 * $urandom_range(0, 3);
      gap_mode = $urandom_range(0, 2);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        cmd = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ;
        case (gap_mode)
          0:       gap = 0;
          1:       gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, MAX_GAP);
          default: gap = $urandom_range(0, MAX_GAP);
        endcase
        send_request(cmd, pick_value(), gap);
      end
      if ($urandom_range(0, 1)) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests (%0d enqueue, %0d dequeue), %0d results checked",
             sb.n_enq + sb.n_deq, sb.n_enq, sb.n_deq, sb.n_checked);
    $display("Hit full queue %0d times and empty queue %0d times",
             sb.n_full, sb.n_empty);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_dpath.sv
rtl/core/sorted_priority_queue.sv
rtl/core/sorted_priority_queue_checker.sv
sim/testbench.sv
